/* sv/rmq_pkg.sv */
`timescale 1ns / 1ps

package rmq_pkg;

    typedef logic [1:0] t_branch;

    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_M00   = 2'd1;
    localparam t_branch BR_M11   = 2'd2;
    localparam t_branch BR_M22   = 2'd3;

endpackage

/* sv/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps
// Stages from an accepted input beat to its output beat: one selection stage,
// SAMPLE_WIDTH square-root stages, one setup stage, SAMPLE_WIDTH+1 divider stages
// and the output register. Throughput: one matrix per cycle when not stalled;
// the square root and the three dividers are pipelined one result bit per stage.
// A stalled output holds the whole pipeline.
// Reset (synchronous, active low) clears all valid bits; the data path has no reset.
module rotation_matrix_to_quaternion #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m00,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m01,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m02,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m10,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m11,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m12,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m20,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m21,
    input  logic signed [SAMPLE_WIDTH-1:0] i_m22,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_w,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_z,
    output rmq_pkg::t_branch               o_branch_taken,
    output logic                           o_degenerate
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int F    = W - 2;
    localparam int EW   = W + 3;
    localparam int RW   = W + 2;
    localparam int XW   = RW + F;
    localparam int SQW  = XW / 2;
    localparam int REMW = SQW + 2;
    localparam int NW   = 2 * W + 1;
    localparam int QB   = W + 1;
    localparam int DW   = SQW + 2;
    localparam int RMW  = DW + 1;

    logic en;
    assign en      = i_ready | ~o_valid;
    assign o_ready = en;

    // Selection stage.
    logic signed [EW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, e_one, e_tr, e_rad;
    logic signed [W:0]    n_a, n_b, n_c;
    rmq_pkg::t_branch     n_br;

    assign e00   = EW'(i_m00);
    assign e01   = EW'(i_m01);
    assign e02   = EW'(i_m02);
    assign e10   = EW'(i_m10);
    assign e11   = EW'(i_m11);
    assign e12   = EW'(i_m12);
    assign e20   = EW'(i_m20);
    assign e21   = EW'(i_m21);
    assign e22   = EW'(i_m22);
    assign e_one = EW'(1) <<< F;
    assign e_tr  = e00 + e11 + e22;

    always_comb begin
        if (e_tr > 0) begin
            n_br  = rmq_pkg::BR_TRACE;
            e_rad = e_tr + e_one;
            n_a   = (W+1)'(e21 - e12);
            n_b   = (W+1)'(e02 - e20);
            n_c   = (W+1)'(e10 - e01);
        end else if (e00 > e11 && e00 > e22) begin
            n_br  = rmq_pkg::BR_M00;
            e_rad = e_one + e00 - e11 - e22;
            n_a   = (W+1)'(e21 - e12);
            n_b   = (W+1)'(e01 + e10);
            n_c   = (W+1)'(e02 + e20);
        end else if (e11 > e22) begin
            n_br  = rmq_pkg::BR_M11;
            e_rad = e_one + e11 - e00 - e22;
            n_a   = (W+1)'(e02 - e20);
            n_b   = (W+1)'(e01 + e10);
            n_c   = (W+1)'(e12 + e21);
        end else begin
            n_br  = rmq_pkg::BR_M22;
            e_rad = e_one + e22 - e00 - e11;
            n_a   = (W+1)'(e10 - e01);
            n_b   = (W+1)'(e02 + e20);
            n_c   = (W+1)'(e12 + e21);
        end
    end

    // Square-root pipeline, one root bit per stage.
    logic                 r_sv   [0:SQW];
    logic [XW-1:0]        r_sx   [0:SQW];
    logic [REMW-1:0]      r_srem [0:SQW];
    logic [SQW-1:0]       r_sroot[0:SQW];
    rmq_pkg::t_branch     r_sbr  [0:SQW];
    logic signed [W:0]    r_sa   [0:SQW];
    logic signed [W:0]    r_sb   [0:SQW];
    logic signed [W:0]    r_sc   [0:SQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
        end
        if (en) begin
            r_sx[0]    <= e_rad[EW-1] ? '0 : {e_rad[RW-1:0], {F{1'b0}}};
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sbr[0]   <= n_br;
            r_sa[0]    <= n_a;
            r_sb[0]    <= n_b;
            r_sc[0]    <= n_c;
        end
    end

    genvar j;
    generate
        for (j = 0; j < SQW; j++) begin : g_sqrt
            logic [REMW+1:0] n_cat, n_test, n_diff;
            logic            n_ge;
            assign n_cat  = {r_srem[j], r_sx[j][XW-1 -: 2]};
            assign n_test = {2'b00, r_sroot[j], 2'b01};
            assign n_diff = n_cat - n_test;
            assign n_ge   = n_cat >= n_test;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[j+1] <= 1'b0;
                end else if (en) begin
                    r_sv[j+1] <= r_sv[j];
                end
                if (en) begin
                    r_sx[j+1]    <= {r_sx[j][XW-3:0], 2'b00};
                    r_srem[j+1]  <= n_ge ? n_diff[REMW-1:0] : n_cat[REMW-1:0];
                    r_sroot[j+1] <= {r_sroot[j][SQW-2:0], n_ge};
                    r_sbr[j+1]   <= r_sbr[j];
                    r_sa[j+1]    <= r_sa[j];
                    r_sb[j+1]    <= r_sb[j];
                    r_sc[j+1]    <= r_sc[j];
                end
            end
        end
    endgenerate

    // Divider setup and pipeline, one quotient bit per stage, three lanes.
    logic [SQW-1:0]   w_sq;
    assign w_sq = r_sroot[SQW];

    logic             r_dv   [0:QB];
    logic [SQW-1:0]   r_dsq  [0:QB];
    rmq_pkg::t_branch r_dbr  [0:QB];
    logic [2:0]       r_dneg [0:QB];
    logic [2:0]       r_dov  [0:QB];
    logic [RMW-1:0]   r_drem [0:QB][0:2];
    logic [QB-1:0]    r_dnq  [0:QB][0:2];

    logic [DW-1:0]    w_d0;
    logic signed [W:0] w_num [0:2];
    assign w_d0     = {w_sq, 2'b00};
    assign w_num[0] = r_sa[SQW];
    assign w_num[1] = r_sb[SQW];
    assign w_num[2] = r_sc[SQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[SQW];
        end
        if (en) begin
            r_dsq[0] <= w_sq;
            r_dbr[0] <= r_sbr[SQW];
        end
    end

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_prep
            logic [W:0]    n_mag;
            logic [NW-1:0] n_n;
            logic [W-1:0]  n_hi;
            logic          n_ov;
            assign n_mag = w_num[k][W] ? (W+1)'(-w_num[k]) : (W+1)'(w_num[k]);
            assign n_n   = {1'b0, n_mag, {(F+1){1'b0}}} + NW'({w_sq, 1'b0});
            assign n_hi  = n_n[NW-1:QB];
            assign n_ov  = RMW'(n_hi) >= RMW'(w_d0);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dneg[0][k]  <= w_num[k][W];
                    r_dov[0][k]   <= n_ov;
                    r_drem[0][k]  <= n_ov ? '0 : RMW'(n_hi);
                    r_dnq[0][k]   <= n_n[QB-1:0];
                end
            end
        end
    endgenerate

    genvar s, l;
    generate
        for (s = 0; s < QB; s++) begin : g_div
            logic [DW-1:0] n_d;
            assign n_d = {r_dsq[s], 2'b00};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[s+1] <= 1'b0;
                end else if (en) begin
                    r_dv[s+1] <= r_dv[s];
                end
                if (en) begin
                    r_dsq[s+1]  <= r_dsq[s];
                    r_dbr[s+1]  <= r_dbr[s];
                    r_dneg[s+1] <= r_dneg[s];
                    r_dov[s+1]  <= r_dov[s];
                end
            end
            for (l = 0; l < 3; l++) begin : g_lane
                logic [RMW-1:0] n_cat;
                logic           n_ge;
                assign n_cat = {r_drem[s][l][RMW-2:0], r_dnq[s][l][QB-1]};
                assign n_ge  = n_cat >= RMW'(n_d);
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_drem[s+1][l] <= n_ge ? n_cat - RMW'(n_d) : n_cat;
                        r_dnq[s+1][l]  <= {r_dnq[s][l][QB-2:0], n_ge};
                    end
                end
            end
        end
    endgenerate

    // Saturation, component placement and output register.
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0] HALF = QB'(1) << (W - 1);

    logic [W-1:0] w_q [0:2];
    logic [W-1:0] w_diag;
    logic [SQW-1:0] w_half;

    generate
        for (k = 0; k < 3; k++) begin : g_sat
            logic [QB-1:0] n_qv;
            assign n_qv = r_dnq[QB][k];
            always_comb begin
                if (r_dneg[QB][k]) begin
                    if (r_dov[QB][k] || n_qv > HALF) begin
                        w_q[k] = SMIN;
                    end else begin
                        w_q[k] = W'(-n_qv);
                    end
                end else begin
                    if (r_dov[QB][k] || n_qv >= HALF) begin
                        w_q[k] = SMAX;
                    end else begin
                        w_q[k] = n_qv[W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign w_half = r_dsq[QB] >> 1;
    assign w_diag = (w_half > SQW'(SMAX)) ? SMAX : w_half[W-1:0];

    logic [W-1:0] n_w, n_x, n_y, n_z;
    logic         n_deg;
    assign n_deg = r_dsq[QB] == '0;

    always_comb begin
        case (r_dbr[QB])
            rmq_pkg::BR_TRACE: begin
                n_w = w_diag; n_x = w_q[0]; n_y = w_q[1]; n_z = w_q[2];
            end
            rmq_pkg::BR_M00: begin
                n_w = w_q[0]; n_x = w_diag; n_y = w_q[1]; n_z = w_q[2];
            end
            rmq_pkg::BR_M11: begin
                n_w = w_q[0]; n_x = w_q[1]; n_y = w_diag; n_z = w_q[2];
            end
            default: begin
                n_w = w_q[0]; n_x = w_q[1]; n_y = w_q[2]; n_z = w_diag;
            end
        endcase
    end

    logic r_ov;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QB];
        end
        if (en) begin
            o_quat_w       <= n_deg ? '0 : n_w;
            o_quat_x       <= n_deg ? '0 : n_x;
            o_quat_y       <= n_deg ? '0 : n_y;
            o_quat_z       <= n_deg ? '0 : n_z;
            o_branch_taken <= r_dbr[QB];
            o_degenerate   <= n_deg;
        end
    end

`ifndef NO_ASSERTIONS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
        o_quat_w == '0 && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0)
        else $error("degenerate beat with nonzero components");

    a_trace_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate && o_branch_taken == rmq_pkg::BR_TRACE |->
        !o_quat_w[W-1])
        else $error("scalar part negative in trace branch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat_w) && $stable(o_branch_taken))
        else $error("stalled output beat changed");
`endif

endmodule
